[rtl/lsmt_pkg.sv]
// lsmt_pkg: shared types, constants and note tables for the light sensor note trigger
// no dependencies; used by every module under rtl

package lsmt_pkg;

    // default values of the top level parameters
    localparam int NumChannelsDef = 8;
    localparam int CalScansDef    = 100;

    // fixed field and state widths
    localparam int ChanW      = 3;
    localparam int SampleBits = 10;
    localparam int SumW       = 17;
    localparam int ThrW       = 10;
    localparam int CalScanW   = 7;
    localparam int ByteW      = 8;

    // configuration register widths
    localparam int MidiChanW  = 4;
    localparam int VelocityW  = 7;
    localparam int PercentW   = 8;
    localparam int RootKeyW   = 4;
    localparam int SensCountW = 4;
    localparam int CfgIndexW  = 3;
    localparam int CfgDataW   = 8;

    // status byte prefixes
    localparam logic [ByteW-1:0] StatusNoteOn  = 8'b1001_0000;
    localparam logic [ByteW-1:0] StatusNoteOff = 8'b1000_0000;

    // register indexes of the configuration port
    typedef enum logic [CfgIndexW-1:0] {
        CfgMidiChannel = 3'd0,
        CfgVelocity    = 3'd1,
        CfgPercentQ8   = 3'd2,
        CfgRootKey     = 3'd3,
        CfgMinorMode   = 3'd4,
        CfgSensorCount = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [ChanW-1:0]      sensor_channel;
        logic [SampleBits-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [ByteW-1:0] midi_byte;
        logic             last_byte;
    } t_out_item;

    // one note message, handed to the output sequencer
    typedef struct packed {
        logic [ByteW-1:0] status;
        logic [ByteW-1:0] note;
        logic [ByteW-1:0] velocity;
    } t_msg;

    // calibration status seen by the top level
    typedef struct packed {
        logic calibrated;
        logic busy;
    } t_cal_status;

    // root note of the scale; keys above eleven fall back to key zero
    function automatic logic [ByteW-1:0] root_note(logic [RootKeyW-1:0] key, logic minor);
        logic [ByteW-1:0] maj;
        logic [ByteW-1:0] mnr;
        case (key)
            4'd1: begin
                maj = 8'd62; mnr = 8'd70;
            end
            4'd2: begin
                maj = 8'd64; mnr = 8'd71;
            end
            4'd3: begin
                maj = 8'd65; mnr = 8'd60;
            end
            4'd4: begin
                maj = 8'd67; mnr = 8'd61;
            end
            4'd5: begin
                maj = 8'd69; mnr = 8'd62;
            end
            4'd6: begin
                maj = 8'd71; mnr = 8'd63;
            end
            4'd7: begin
                maj = 8'd61; mnr = 8'd64;
            end
            4'd8: begin
                maj = 8'd63; mnr = 8'd65;
            end
            4'd9: begin
                maj = 8'd66; mnr = 8'd66;
            end
            4'd10: begin
                maj = 8'd68; mnr = 8'd67;
            end
            4'd11: begin
                maj = 8'd70; mnr = 8'd68;
            end
            default: begin
                maj = 8'd60; mnr = 8'd69;
            end
        endcase
        return minor ? mnr : maj;
    endfunction

    // semitone offset of a channel above the root
    function automatic logic [ByteW-1:0] scale_offset(logic [ChanW-1:0] ch, logic minor);
        logic [ByteW-1:0] maj;
        logic [ByteW-1:0] mnr;
        case (ch)
            3'd1: begin
                maj = 8'd2;  mnr = 8'd2;
            end
            3'd2: begin
                maj = 8'd4;  mnr = 8'd3;
            end
            3'd3: begin
                maj = 8'd5;  mnr = 8'd5;
            end
            3'd4: begin
                maj = 8'd7;  mnr = 8'd7;
            end
            3'd5: begin
                maj = 8'd9;  mnr = 8'd8;
            end
            3'd6: begin
                maj = 8'd11; mnr = 8'd10;
            end
            3'd7: begin
                maj = 8'd12; mnr = 8'd12;
            end
            default: begin
                maj = 8'd0;  mnr = 8'd0;
            end
        endcase
        return minor ? mnr : maj;
    endfunction

    function automatic logic [ByteW-1:0] note_for(logic [RootKeyW-1:0] key, logic minor,
                                                  logic [ChanW-1:0] ch);
        return root_note(key, minor) + scale_offset(ch, minor);
    endfunction

endpackage

[rtl/lsmt_calib.sv]
// lsmt_calib: per-channel calibration sums, scan counter and threshold pass
// depends on lsmt_pkg

module lsmt_calib #(
    parameter int NUM_CHANNELS = lsmt_pkg::NumChannelsDef,
    parameter int CAL_SCANS    = lsmt_pkg::CalScansDef,
    localparam int ChW         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_add,
    input  logic [ChW-1:0]                  i_idx,
    input  logic [lsmt_pkg::SampleBits-1:0] i_sample,
    output lsmt_pkg::t_cal_status           o_status,
    output logic [lsmt_pkg::ThrW-1:0]       o_threshold
);

    localparam int SumW       = lsmt_pkg::SumW;
    localparam int ThrW       = lsmt_pkg::ThrW;
    localparam int CalScanW   = lsmt_pkg::CalScanW;
    // reciprocal of the scan count, exact for every sum below 2**SumW
    localparam int RecipShift = SumW + CalScanW;
    localparam int RecipW     = RecipShift + 1;
    localparam int ProdW      = SumW + RecipW;
    localparam logic [RecipW-1:0] RecipMul =
        RecipW'((2 ** RecipShift + CAL_SCANS - 1) / CAL_SCANS);
    localparam logic [ChW-1:0]      LastIdx  = ChW'(NUM_CHANNELS - 1);
    localparam logic [CalScanW-1:0] ScanDone = CalScanW'(CAL_SCANS);

    logic [SumW-1:0]     r_sum [NUM_CHANNELS];
    logic [ThrW-1:0]     r_threshold [NUM_CHANNELS];
    logic [CalScanW-1:0] r_scan_count;
    logic                r_calibrated;
    logic                r_busy;
    logic [ChW-1:0]      r_sweep_idx;

    logic [ChW-1:0]      rd_idx;
    logic [SumW-1:0]     sum_rd;
    logic [SumW:0]       sum_ext;
    logic [SumW-1:0]     sum_sat;
    logic [CalScanW-1:0] scan_next;
    logic                scan_end;
    logic                cal_end;
    logic [ProdW-1:0]    prod;
    logic [SumW-1:0]     quot;
    logic [ThrW-1:0]     thr_sat;

    // one read port: the sweep index while the threshold pass runs
    assign rd_idx  = r_busy ? r_sweep_idx : i_idx;
    assign sum_rd  = r_sum[rd_idx];
    assign sum_ext = {1'b0, sum_rd} + (SumW + 1)'(i_sample);
    assign sum_sat = sum_ext[SumW] ? {SumW{1'b1}} : sum_ext[SumW-1:0];

    assign scan_next = r_scan_count + 1'b1;
    assign scan_end  = i_add && (i_idx == LastIdx);
    assign cal_end   = scan_end && (scan_next >= ScanDone);

    assign prod    = ProdW'(sum_rd) * ProdW'(RecipMul);
    assign quot    = prod[RecipShift +: SumW];
    assign thr_sat = (|quot[SumW-1:ThrW]) ? {ThrW{1'b1}} : quot[ThrW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_sum[i]       <= '0;
                r_threshold[i] <= '0;
            end
            r_scan_count <= '0;
            r_calibrated <= 1'b0;
            r_busy       <= 1'b0;
            r_sweep_idx  <= '0;
        end else begin
            if (i_add) begin
                r_sum[i_idx] <= sum_sat;
            end
            if (scan_end) begin
                r_scan_count <= scan_next;
            end
            if (cal_end) begin
                r_busy      <= 1'b1;
                r_sweep_idx <= '0;
            end
            if (r_busy) begin
                r_threshold[r_sweep_idx] <= thr_sat;
                if (r_sweep_idx == LastIdx) begin
                    r_busy       <= 1'b0;
                    r_calibrated <= 1'b1;
                end else begin
                    r_sweep_idx <= r_sweep_idx + 1'b1;
                end
            end
        end
    end

    assign o_status.calibrated = r_calibrated;
    assign o_status.busy       = r_busy;
    assign o_threshold         = r_threshold[i_idx];

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_count <= ScanDone)
        else $error("scan counter passed the calibration length");

    a_cal_after_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_calibrated) |-> $past(r_busy))
        else $error("calibrated without a threshold pass");

    a_no_add_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_add)
        else $error("sample added during the threshold pass");

endmodule

[rtl/lsmt_msg_out.sv]
// lsmt_msg_out: output register that sends a note message as three bytes
// depends on lsmt_pkg

module lsmt_msg_out (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  lsmt_pkg::t_msg        i_msg,
    output logic                  o_free,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output lsmt_pkg::t_out_item   o_out_item
);

    typedef enum logic [1:0] {
        BYTE_STATUS,
        BYTE_NOTE,
        BYTE_VELOCITY
    } t_byte_sel;

    logic           r_valid;
    t_byte_sel      r_sel;
    lsmt_pkg::t_msg r_msg;

    // free now, or the last byte leaves this cycle
    assign o_free = !r_valid || ((r_sel == BYTE_VELOCITY) && !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= BYTE_STATUS;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_sel   <= BYTE_STATUS;
            r_msg   <= i_msg;
        end else if (r_valid && !i_out_stall) begin
            case (r_sel)
                BYTE_STATUS: r_sel <= BYTE_NOTE;
                BYTE_NOTE:   r_sel <= BYTE_VELOCITY;
                default: begin
                    r_valid <= 1'b0;
                    r_sel   <= BYTE_STATUS;
                end
            endcase
        end
    end

    always_comb begin
        o_out_item.last_byte = (r_sel == BYTE_VELOCITY);
        case (r_sel)
            BYTE_STATUS: o_out_item.midi_byte = r_msg.status;
            BYTE_NOTE:   o_out_item.midi_byte = r_msg.note;
            default:     o_out_item.midi_byte = r_msg.velocity;
        endcase
    end

    assign o_out_valid = r_valid;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("message loaded over one still being sent");

endmodule

[rtl/light_sensor_midi_note_trigger.sv]
// light_sensor_midi_note_trigger: top level, input register, config registers, note decision
// depends on lsmt_pkg, lsmt_calib and lsmt_msg_out

// Light-sensor note trigger. Each input item is one converter sample with its
// channel number. Until CAL_SCANS scans have been seen (a scan ends on a
// sample of channel NUM_CHANNELS-1) every sample is summed per channel and no
// item comes out. On the sample that ends the last scan the block runs a
// threshold pass, one channel per cycle through a single reciprocal
// multiplier; one more item may enter the input register meanwhile, and it
// waits there with stall high until the pass is over. After that a channel
// below sensor_count is pressed when its sample lies under
// (threshold * percent_q8) >> 8, and each change of pressed state sends a
// note-on or note-off message as three output items: status, note, velocity,
// with last_byte set on the velocity item. Rate: samples that send nothing
// stream at one per clock; a sample that sends a message occupies the byte
// sequencer (one byte per cycle, plus any output stall), and the next
// message-making sample waits for it. Samples of channels at or above
// NUM_CHANNELS are dropped. Configuration registers are written on the plain
// write port; the user must write them only while idle, as the block itself
// does not enforce it.

module light_sensor_midi_note_trigger #(
    parameter int NUM_CHANNELS = lsmt_pkg::NumChannelsDef,
    parameter int CAL_SCANS    = lsmt_pkg::CalScansDef
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  lsmt_pkg::t_in_item             i_in_item,
    // midi byte channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output lsmt_pkg::t_out_item            o_out_item,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [lsmt_pkg::CfgIndexW-1:0] i_cfg_index,
    input  logic [lsmt_pkg::CfgDataW-1:0]  i_cfg_wdata
);

    localparam int ChW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int ThrW = lsmt_pkg::ThrW;
    localparam int PercentW = lsmt_pkg::PercentW;
    localparam int LimitW = ThrW + PercentW;

    // configuration registers
    logic [lsmt_pkg::MidiChanW-1:0]  r_midi_channel;
    logic [lsmt_pkg::VelocityW-1:0]  r_velocity;
    logic [PercentW-1:0]             r_percent_q8;
    logic [lsmt_pkg::RootKeyW-1:0]   r_root_key;
    logic                            r_minor_mode;
    logic [lsmt_pkg::SensCountW-1:0] r_sensor_count;

    // input register
    logic               r_in_valid;
    lsmt_pkg::t_in_item r_in;

    // one sounding flag per channel
    logic [NUM_CHANNELS-1:0] r_note_sounding;

    lsmt_pkg::t_cal_status cal_status;
    lsmt_pkg::t_msg        msg;
    logic [ChW-1:0]        ch_idx;
    logic [ThrW-1:0]       threshold;
    logic [LimitW-1:0]     limit_full;
    logic [ThrW-1:0]       limit;
    logic                  ch_ok;
    logic                  pressed;
    logic                  change;
    logic                  out_free;
    logic                  advance;
    logic                  msg_load;
    logic                  cal_add;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_midi_channel <= '0;
            r_velocity     <= lsmt_pkg::VelocityW'(64);
            r_percent_q8   <= PercentW'(204);
            r_root_key     <= '0;
            r_minor_mode   <= 1'b0;
            r_sensor_count <= lsmt_pkg::SensCountW'(8);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lsmt_pkg::CfgMidiChannel:
                    r_midi_channel <= i_cfg_wdata[lsmt_pkg::MidiChanW-1:0];
                lsmt_pkg::CfgVelocity:
                    r_velocity     <= i_cfg_wdata[lsmt_pkg::VelocityW-1:0];
                lsmt_pkg::CfgPercentQ8:
                    r_percent_q8   <= i_cfg_wdata[PercentW-1:0];
                lsmt_pkg::CfgRootKey:
                    r_root_key     <= i_cfg_wdata[lsmt_pkg::RootKeyW-1:0];
                lsmt_pkg::CfgMinorMode:
                    r_minor_mode   <= i_cfg_wdata[0];
                lsmt_pkg::CfgSensorCount:
                    r_sensor_count <= i_cfg_wdata[lsmt_pkg::SensCountW-1:0];
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    // the held item is decided this cycle unless the byte sequencer is still busy
    // with a message and this item makes another, or the threshold pass runs
    assign ch_idx     = r_in.sensor_channel[ChW-1:0];
    assign ch_ok      = ({1'b0, r_in.sensor_channel} < (lsmt_pkg::ChanW + 1)'(NUM_CHANNELS));
    assign limit_full = LimitW'(threshold) * LimitW'(r_percent_q8);
    assign limit      = limit_full[LimitW-1:PercentW];
    assign pressed    = ({1'b0, r_in.sensor_channel} < r_sensor_count)
                        && (r_in.sample < limit);
    assign change     = ch_ok && cal_status.calibrated
                        && (pressed != r_note_sounding[ch_idx]);
    assign advance    = r_in_valid && !cal_status.busy && (!change || out_free);
    assign msg_load   = advance && change;
    assign cal_add    = advance && ch_ok && !cal_status.calibrated;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_note_sounding <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (msg_load) begin
                r_note_sounding[ch_idx] <= pressed;
            end
        end
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
    end

    // message built from the current registers
    assign msg.status   = (pressed ? lsmt_pkg::StatusNoteOn : lsmt_pkg::StatusNoteOff)
                          | lsmt_pkg::ByteW'(r_midi_channel);
    assign msg.note     = lsmt_pkg::note_for(r_root_key, r_minor_mode, r_in.sensor_channel);
    assign msg.velocity = lsmt_pkg::ByteW'(r_velocity);

    lsmt_calib #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .CAL_SCANS    (CAL_SCANS)
    ) u_calib (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_add       (cal_add),
        .i_idx       (ch_idx),
        .i_sample    (r_in.sample),
        .o_status    (cal_status),
        .o_threshold (threshold)
    );

    lsmt_msg_out u_msg_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (msg_load),
        .i_msg       (msg),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    a_out_after_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> cal_status.calibrated)
        else $error("output item before calibration finished");

    a_note_needs_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_note_sounding != $past(r_note_sounding)) |-> $past(msg_load))
        else $error("note state changed without a message");

endmodule

[test/tb_light_sensor_midi_note_trigger.sv]
// tb_light_sensor_midi_note_trigger: self-checking bench for the light sensor note trigger
// depends on lsmt_pkg and light_sensor_midi_note_trigger; drives samples, checks midi bytes
// against an in-bench note predictor, with random sender gaps and receiver stalls

module tb_light_sensor_midi_note_trigger;

    import lsmt_pkg::*;

    localparam int NumCh       = NumChannelsDef;
    localparam int CalScans    = CalScansDef;
    localparam int SumMax      = 131071;
    localparam int ThrMax      = 1023;
    localparam int SettlePad   = 8;
    localparam int EndPad      = 16;
    localparam int HoldCycles  = 400;
    localparam int QuietLimit  = 3000;
    localparam int RandPhases  = 6;
    localparam int PhaseItems  = 45;

    // scale tables, index 0 first
    localparam logic [0:11][7:0] MajorRoots = {8'd60, 8'd62, 8'd64, 8'd65, 8'd67, 8'd69,
                                               8'd71, 8'd61, 8'd63, 8'd66, 8'd68, 8'd70};
    localparam logic [0:11][7:0] MinorRoots = {8'd69, 8'd70, 8'd71, 8'd60, 8'd61, 8'd62,
                                               8'd63, 8'd64, 8'd65, 8'd66, 8'd67, 8'd68};
    localparam logic [0:7][7:0]  MajorSteps = {8'd0, 8'd2, 8'd4, 8'd5, 8'd7, 8'd9, 8'd11, 8'd12};
    localparam logic [0:7][7:0]  MinorSteps = {8'd0, 8'd2, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12};

    // up to three midi bytes caused by one sample, status byte in slot 0
    typedef struct packed {
        logic [1:0]          count;
        t_out_item [2:0]     items;
    } t_midi_msg;

    typedef enum logic [1:0] {
        RowSample,
        RowConfig,
        RowCalibrate
    } t_row_kind;

    // one line of the directed table; sel is a channel or a register index
    typedef struct packed {
        t_row_kind   kind;
        logic [2:0]  sel;
        logic [9:0]  value;
        logic        typed;
        t_midi_msg   msg;
    } t_row;

    localparam t_midi_msg NoMsg = '0;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_in_item             in_item = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_item;
    logic                 cfg_we = 1'b0;
    logic [CfgIndexW-1:0] cfg_index = '0;
    logic [CfgDataW-1:0]  cfg_wdata = '0;

    // predictor copy of the registers, at their reset values
    logic [3:0] reg_midi_chan = 4'd0;
    logic [6:0] reg_velocity  = 7'd64;
    logic [7:0] reg_percent   = 8'd204;
    logic [3:0] reg_root      = 4'd0;
    logic       reg_minor     = 1'b0;
    logic [3:0] reg_sensors   = 4'd8;

    // predictor copy of the block state
    logic [16:0] cal_sum  [NumCh];
    logic [9:0]  thr      [NumCh];
    logic [6:0]  scan_cnt = '0;
    logic        cal_done = 1'b0;
    logic        sounding [NumCh];

    t_out_item midi_bytes_due [$];
    t_row      stim_rows [$];
    int        cal_level [NumCh];
    int        mismatch_count = 0;
    int        burst_left = 0;
    int        quiet_cycles = 0;

    // receiver side
    logic      hold_req = 1'b0;
    logic      hold_taken = 1'b0;
    int        hold_left = 0;
    logic [7:0] stall_tick = '0;
    t_out_item want;

    light_sensor_midi_note_trigger uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial begin
        for (int c = 0; c < NumCh; c++) begin
            cal_sum[c]  = '0;
            thr[c]      = '0;
            sounding[c] = 1'b0;
        end
    end

    function automatic t_midi_msg note_msg(logic [7:0] st, logic [7:0] nt, logic [7:0] vel);
        t_midi_msg m;
        m.count = 2'd3;
        m.items = {{vel, 1'b1}, {nt, 1'b0}, {st, 1'b0}};
        return m;
    endfunction

    function automatic int trigger_limit(logic [2:0] ch);
        return (int'(thr[ch]) * int'(reg_percent)) >> 8;
    endfunction

    // sums during calibration, then decides the pressed state and the message it sends
    function automatic t_midi_msg derive_midi_bytes(t_in_item it);
        logic [2:0] ch;
        int         total;
        logic       pressed;
        logic [3:0] key;
        logic [7:0] status;
        logic [7:0] note;
        ch = it.sensor_channel;
        if (!cal_done) begin
            total = int'(cal_sum[ch]) + int'(it.sample);
            cal_sum[ch] = (total > SumMax) ? 17'(SumMax) : 17'(total);
            if (int'(ch) == NumCh - 1) begin
                scan_cnt = scan_cnt + 7'd1;
                if (int'(scan_cnt) >= CalScans) begin
                    for (int c = 0; c < NumCh; c++) begin
                        total = int'(cal_sum[c]) / CalScans;
                        thr[c] = (total > ThrMax) ? 10'(ThrMax) : 10'(total);
                    end
                    cal_done = 1'b1;
                end
            end
            return NoMsg;
        end
        pressed = ({1'b0, ch} < reg_sensors) && (int'(it.sample) < trigger_limit(ch));
        if (pressed == sounding[ch]) begin
            return NoMsg;
        end
        sounding[ch] = pressed;
        // keys past the last table entry fall back to key zero
        key = (reg_root > 4'd11) ? 4'd0 : reg_root;
        note = reg_minor ? MinorRoots[key] + MinorSteps[ch] : MajorRoots[key] + MajorSteps[ch];
        status = (pressed ? StatusNoteOn : StatusNoteOff) | {4'b0000, reg_midi_chan};
        return note_msg(status, note, {1'b0, reg_velocity});
    endfunction

    function automatic void add_row(t_row_kind k, logic [2:0] sel, logic [9:0] v,
                                    logic typed, t_midi_msg msg);
        t_row r;
        r.kind  = k;
        r.sel   = sel;
        r.value = v;
        r.typed = typed;
        r.msg   = msg;
        stim_rows.push_back(r);
    endfunction

    task automatic report_mismatch(string what, int exp_val, int got_val);
        mismatch_count++;
        $display("%0t: %s expected %0h actual %0h", $time, what, exp_val, got_val);
    endtask

    // offers one item in bursts with random gaps, then books its expected bytes
    task automatic offer_sample(t_in_item it, logic typed, t_midi_msg typed_msg);
        t_midi_msg m;
        int        gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        burst_left--;
        m = derive_midi_bytes(it);
        if (typed) begin
            m = typed_msg;
        end
        for (int i = 0; i < int'(m.count); i++) begin
            midi_bytes_due.push_back(m.items[i]);
        end
    endtask

    // stop sending and let every pending byte and the pipeline drain
    task automatic settle_block();
        in_valid <= 1'b0;
        burst_left = 0;
        while (midi_bytes_due.size() != 0) @(posedge clk);
        repeat (SettlePad) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [7:0] v);
        case (idx)
            CfgMidiChannel: reg_midi_chan = v[3:0];
            CfgVelocity:    reg_velocity  = v[6:0];
            CfgPercentQ8:   reg_percent   = v;
            CfgRootKey:     reg_root      = v[3:0];
            CfgMinorMode:   reg_minor     = v[0];
            CfgSensorCount: reg_sensors   = v[3:0];
            default: ;
        endcase
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // receiver: one long hold-off on request, otherwise a rotating stall pattern
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HoldCycles;
            out_stall  <= 1'b1;
        end else begin
            stall_tick <= stall_tick + 8'd1;
            case (stall_tick[7:6])
                2'd0: out_stall <= 1'b0;
                2'd1: out_stall <= ($urandom_range(0, 3) == 0);
                2'd2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= stall_tick[0];
            endcase
        end
    end

    // byte checker, oldest expectation first
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (midi_bytes_due.size() == 0) begin
                report_mismatch("unexpected midi_byte", 0, int'(out_item.midi_byte));
            end else begin
                want = midi_bytes_due.pop_front();
                if (out_item.midi_byte !== want.midi_byte) begin
                    report_mismatch("midi_byte", int'(want.midi_byte), int'(out_item.midi_byte));
                end
                if (out_item.last_byte !== want.last_byte) begin
                    report_mismatch("last_byte", int'(want.last_byte), int'(out_item.last_byte));
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk) begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_row     row;
        t_in_item it;
        int       v;
        int       lim;
        int       pick;

        // calibration rows: nothing comes out, the first ch7 sample already ends a scan
        add_row(RowSample, 3'd3, 10'd0, 1'b1, NoMsg);
        add_row(RowSample, 3'd7, 10'd1023, 1'b1, NoMsg);
        add_row(RowCalibrate, 3'd0, 10'd0, 1'b0, NoMsg);
        // ch0 sum saturates, so its threshold is clamped to 1023 and the limit is 815
        add_row(RowSample, 3'd0, 10'd0, 1'b1, note_msg(StatusNoteOn, 8'd60, 8'd64));
        add_row(RowSample, 3'd0, 10'd814, 1'b1, NoMsg);
        add_row(RowSample, 3'd0, 10'd815, 1'b1, note_msg(StatusNoteOff, 8'd60, 8'd64));
        add_row(RowSample, 3'd7, 10'd0, 1'b0, NoMsg);
        add_row(RowConfig, CfgMidiChannel, 10'd15, 1'b0, NoMsg);
        add_row(RowConfig, CfgVelocity, 10'd127, 1'b0, NoMsg);
        add_row(RowSample, 3'd7, 10'd1023, 1'b0, NoMsg);
        add_row(RowSample, 3'd5, 10'd0, 1'b0, NoMsg);
        // no sensors: a sounding note is released
        add_row(RowConfig, CfgSensorCount, 10'd0, 1'b0, NoMsg);
        add_row(RowSample, 3'd5, 10'd0, 1'b0, NoMsg);
        add_row(RowSample, 3'd2, 10'd0, 1'b0, NoMsg);
        // count above the channel total, key above eleven, minor scale
        add_row(RowConfig, CfgSensorCount, 10'd15, 1'b0, NoMsg);
        add_row(RowConfig, CfgRootKey, 10'd15, 1'b0, NoMsg);
        add_row(RowConfig, CfgMinorMode, 10'd1, 1'b0, NoMsg);
        add_row(RowSample, 3'd3, 10'd0, 1'b0, NoMsg);
        // key changes under a sounding note, the release names the new note
        add_row(RowConfig, CfgRootKey, 10'd11, 1'b0, NoMsg);
        add_row(RowSample, 3'd3, 10'd1023, 1'b0, NoMsg);
        add_row(RowConfig, CfgPercentQ8, 10'd0, 1'b0, NoMsg);
        add_row(RowSample, 3'd1, 10'd0, 1'b0, NoMsg);
        add_row(RowSample, 3'd0, 10'd0, 1'b0, NoMsg);
        add_row(RowConfig, CfgPercentQ8, 10'd255, 1'b0, NoMsg);
        add_row(RowConfig, CfgMidiChannel, 10'd0, 1'b0, NoMsg);
        add_row(RowConfig, CfgVelocity, 10'd0, 1'b0, NoMsg);
        // limit is 1019 here
        add_row(RowSample, 3'd0, 10'd1019, 1'b0, NoMsg);
        add_row(RowSample, 3'd0, 10'd1018, 1'b0, NoMsg);
        add_row(RowSample, 3'd0, 10'd1023, 1'b0, NoMsg);
        add_row(RowSample, 3'd6, 10'd0, 1'b0, NoMsg);
        add_row(RowSample, 3'd4, 10'd0, 1'b0, NoMsg);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < stim_rows.size(); r++) begin
            row = stim_rows[r];
            case (row.kind)
                RowSample: begin
                    it.sensor_channel = row.sel;
                    it.sample         = row.value;
                    offer_sample(it, row.typed, row.msg);
                end
                RowConfig: begin
                    settle_block();
                    write_reg(t_cfg_reg'(row.sel), row.value[7:0]);
                end
                default: begin
                    // full scans at a noisy level per channel, ch0 pinned high with
                    // extra samples early on so its sum saturates
                    for (int c = 0; c < NumCh; c++) begin
                        cal_level[c] = (c == 0) ? 1023 : int'($urandom_range(150, 1023));
                    end
                    while (!cal_done) begin
                        for (int c = 0; c < NumCh; c++) begin
                            if (c == 0 && scan_cnt < 7'd40) begin
                                it.sensor_channel = 3'd0;
                                it.sample         = 10'd1023;
                                offer_sample(it, 1'b0, NoMsg);
                            end
                            v = cal_level[c] + int'($urandom_range(0, 64)) - 32;
                            v = (v < 0) ? 0 : ((v > 1023) ? 1023 : v);
                            it.sensor_channel = 3'(c);
                            it.sample         = 10'(v);
                            offer_sample(it, 1'b0, NoMsg);
                        end
                    end
                end
            endcase
        end

        // random phases, each with a fresh register setting
        for (int ph = 0; ph < RandPhases; ph++) begin
            settle_block();
            write_reg(CfgMidiChannel, 8'($urandom_range(0, 15)));
            write_reg(CfgVelocity, 8'($urandom_range(0, 127)));
            write_reg(CfgPercentQ8, 8'($urandom_range(100, 255)));
            write_reg(CfgRootKey, 8'($urandom_range(0, 15)));
            write_reg(CfgMinorMode, 8'($urandom_range(0, 1)));
            write_reg(CfgSensorCount, (ph == 0) ? 8'd8 : 8'($urandom_range(0, 15)));
            if (ph == 1) begin
                hold_req <= 1'b1;
            end
            for (int k = 0; k < PhaseItems; k++) begin
                it.sensor_channel = 3'($urandom_range(0, 7));
                lim  = trigger_limit(it.sensor_channel);
                pick = $urandom_range(0, 9);
                // mostly press and release around the limit so notes keep changing
                if (pick < 4) begin
                    v = (lim > 0) ? int'($urandom_range(0, lim - 1)) : int'($urandom_range(0, 1023));
                end else if (pick < 8) begin
                    v = $urandom_range(lim, 1023);
                end else if (pick == 8) begin
                    v = $urandom_range(0, 1023);
                end else begin
                    v = ($urandom_range(0, 1) != 0) ? 1023 : 0;
                end
                it.sample = 10'(v);
                offer_sample(it, 1'b0, NoMsg);
            end
        end

        in_valid <= 1'b0;
        while (midi_bytes_due.size() != 0) @(posedge clk);
        repeat (EndPad) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[files.f]
rtl/lsmt_pkg.sv
rtl/lsmt_calib.sv
rtl/lsmt_msg_out.sv
rtl/light_sensor_midi_note_trigger.sv
test/tb_light_sensor_midi_note_trigger.sv
